>>> hdl/bf3d_pkg.sv
`default_nettype none

package bf3d_pkg;

    localparam int COORD_BITS    = 12;
    localparam int DEPTH_BITS    = 16;
    localparam int DIM_BITS      = 13;
    localparam int OUT_BITS      = DEPTH_BITS + 1;
    localparam int WGT_BITS      = 16;
    localparam int WGT_FRAC      = 15;
    localparam int PROD_BITS     = WGT_BITS + DEPTH_BITS;
    localparam int WSUM_BITS     = WGT_BITS + 3;
    localparam int NUM_BITS      = WSUM_BITS + DEPTH_BITS;
    localparam int GRP_WSUM_BITS = WGT_BITS + 2;
    localparam int GRP_NUM_BITS  = PROD_BITS + 2;
    localparam int WIN_SIZE      = 9;
    localparam int GRP_SIZE      = 3;
    localparam int GRP_COUNT     = WIN_SIZE / GRP_SIZE;
    localparam int RANGE_SHIFT   = 6;
    localparam int RANGE_BIAS    = 32;
    localparam int K_BITS        = DEPTH_BITS + 1 - RANGE_SHIFT;
    localparam int MAX_DIM       = 4096;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [DIM_BITS-1:0]   t_dim;
    typedef logic [WGT_BITS-1:0]   t_wgt;
    typedef logic [PROD_BITS-1:0]  t_prod;
    typedef logic [WSUM_BITS-1:0]  t_wsum;
    typedef logic [NUM_BITS-1:0]   t_num;

    typedef struct packed {
        t_coord row;
        t_coord col;
        t_depth centre;
    } t_tag;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam t_wgt W_CENTER = 16'd32768;
    localparam t_wgt W_EDGE   = 16'd23155;
    localparam t_wgt W_CORNER = 16'd16363;

    // window order: centre, then neighbours row by row; 0 = up/left, 2 = down/right
    localparam logic [1:0] WIN_ROW [WIN_SIZE] =
        '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] WIN_COL [WIN_SIZE] =
        '{2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam t_wgt WIN_SPATIAL [WIN_SIZE] =
        '{W_CENTER, W_CORNER, W_EDGE, W_CORNER, W_EDGE,
          W_EDGE, W_CORNER, W_EDGE, W_CORNER};

    // Q1.15 range Gaussian, index is |diff| in quarter depth units
    function automatic t_wgt range_weight(input logic [K_BITS-1:0] k);
        t_wgt w;
        case (k)
            K_BITS'(0):  w = 16'd32768;
            K_BITS'(1):  w = 16'd32065;
            K_BITS'(2):  w = 16'd30044;
            K_BITS'(3):  w = 16'd26954;
            K_BITS'(4):  w = 16'd23155;
            K_BITS'(5):  w = 16'd19047;
            K_BITS'(6):  w = 16'd15002;
            K_BITS'(7):  w = 16'd11314;
            K_BITS'(8):  w = 16'd8171;
            K_BITS'(9):  w = 16'd5649;
            K_BITS'(10): w = 16'd3741;
            K_BITS'(11): w = 16'd2372;
            K_BITS'(12): w = 16'd1440;
            K_BITS'(13): w = 16'd837;
            K_BITS'(14): w = 16'd466;
            K_BITS'(15): w = 16'd248;
            K_BITS'(16): w = 16'd127;
            K_BITS'(17): w = 16'd62;
            K_BITS'(18): w = 16'd29;
            K_BITS'(19): w = 16'd13;
            K_BITS'(20): w = 16'd6;
            K_BITS'(21): w = 16'd2;
            K_BITS'(22): w = 16'd1;
            default:     w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bf3d_in_if.sv
`default_nettype none

interface bf3d_in_if import bf3d_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pixel_row;
    t_coord pixel_col;
    t_depth center_depth;
    t_depth up_left_depth;
    t_depth up_depth;
    t_depth up_right_depth;
    t_depth left_depth;
    t_depth right_depth;
    t_depth down_left_depth;
    t_depth down_depth;
    t_depth down_right_depth;

    modport source (
        output valid, pixel_row, pixel_col, center_depth, up_left_depth, up_depth,
               up_right_depth, left_depth, right_depth, down_left_depth, down_depth,
               down_right_depth,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, pixel_col, center_depth, up_left_depth, up_depth,
               up_right_depth, left_depth, right_depth, down_left_depth, down_depth,
               down_right_depth,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/bf3d_out_if.sv
`default_nettype none

interface bf3d_out_if import bf3d_pkg::*; ();
    logic                valid;
    logic                ready;
    t_coord              out_row;
    t_coord              out_col;
    logic [OUT_BITS-1:0] filtered_depth;

    modport source (
        output valid, out_row, out_col, filtered_depth,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, filtered_depth,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/bilateral_filter_3x3_depth_core.sv
`default_nettype none

// 3x3 bilateral depth filter. Each input word carries a pixel position, its
// Q8.8 depth and its eight neighbour depths; each output word returns the
// position with the weighted window mean plus the centre depth (Q9.8).
// Window elements outside the image set by the width/height registers are
// dropped. One word is accepted per clock unless the output stalls. Stages:
// three weight, two adder-tree, a dividend stage, the 16-stage restoring
// divider (one quotient bit per stage) and the output register. A stalled
// output holds the whole pipeline. Register writes go through i_cfg_we with
// i_cfg_idx 0 = image_width, 1 = image_height; values above 4096 are clamped.

module bilateral_filter_3x3_depth_core import bf3d_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_idx,
    input  wire t_dim     i_cfg_wdata,
    bf3d_in_if.sink       i_pix,
    bf3d_out_if.source    o_res
);

    t_dim                r_width;
    t_dim                r_height;
    t_dim                w_cfg_dim;
    logic                w_en;
    t_tag                w_in_tag;
    t_depth              w_depth [WIN_SIZE];
    logic                w_wt_vld;
    t_tag                w_wt_tag;
    t_wgt                w_wt_wgt  [WIN_SIZE];
    t_prod               w_wt_prod [WIN_SIZE];
    logic                w_ac_vld;
    t_tag                w_ac_tag;
    t_wsum               w_ac_wsum;
    t_num                w_ac_num;
    logic                w_dv_vld;
    t_tag                w_dv_tag;
    t_depth              w_dv_quot;
    logic                r_out_vld;
    t_coord              r_out_row;
    t_coord              r_out_col;
    logic [OUT_BITS-1:0] r_out_depth;

    assign w_cfg_dim = (int'(i_cfg_wdata) > MAX_DIM) ? DIM_BITS'(MAX_DIM) : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(WIDTH_RESET);
            r_height <= DIM_BITS'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= w_cfg_dim;
                CFG_IMAGE_HEIGHT: r_height <= w_cfg_dim;
                default: ;
            endcase
        end
    end

    assign w_en        = !r_out_vld || o_res.ready;
    assign i_pix.ready = w_en;

    assign w_in_tag.row    = i_pix.pixel_row;
    assign w_in_tag.col    = i_pix.pixel_col;
    assign w_in_tag.centre = i_pix.center_depth;

    assign w_depth[0] = i_pix.center_depth;
    assign w_depth[1] = i_pix.up_left_depth;
    assign w_depth[2] = i_pix.up_depth;
    assign w_depth[3] = i_pix.up_right_depth;
    assign w_depth[4] = i_pix.left_depth;
    assign w_depth[5] = i_pix.right_depth;
    assign w_depth[6] = i_pix.down_left_depth;
    assign w_depth[7] = i_pix.down_depth;
    assign w_depth[8] = i_pix.down_right_depth;

    bf3d_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_pix.valid),
        .i_tag    (w_in_tag),
        .i_depth  (w_depth),
        .i_width  (r_width),
        .i_height (r_height),
        .o_vld    (w_wt_vld),
        .o_tag    (w_wt_tag),
        .o_wgt    (w_wt_wgt),
        .o_prod   (w_wt_prod)
    );

    bf3d_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_wt_vld),
        .i_tag   (w_wt_tag),
        .i_wgt   (w_wt_wgt),
        .i_prod  (w_wt_prod),
        .o_vld   (w_ac_vld),
        .o_tag   (w_ac_tag),
        .o_wsum  (w_ac_wsum),
        .o_num   (w_ac_num)
    );

    bf3d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ac_vld),
        .i_tag   (w_ac_tag),
        .i_wsum  (w_ac_wsum),
        .i_num   (w_ac_num),
        .o_vld   (w_dv_vld),
        .o_tag   (w_dv_tag),
        .o_quot  (w_dv_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_row   <= w_dv_tag.row;
            r_out_col   <= w_dv_tag.col;
            r_out_depth <= {1'b0, w_dv_quot} + {1'b0, w_dv_tag.centre};
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.out_row        = r_out_row;
    assign o_res.out_col        = r_out_col;
    assign o_res.filtered_depth = r_out_depth;

endmodule

`default_nettype wire

>>> hdl/bf3d_weight.sv
`default_nettype none

module bf3d_weight import bf3d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_tag  i_tag,
    input  wire t_depth i_depth [WIN_SIZE],
    input  wire t_dim  i_width,
    input  wire t_dim  i_height,
    output logic       o_vld,
    output t_tag       o_tag,
    output t_wgt       o_wgt [WIN_SIZE],
    output t_prod      o_prod [WIN_SIZE]
);

    // stage A: border mask and range weight
    logic [2:0]   n_row_ok;
    logic [2:0]   n_col_ok;
    logic         n_a_in [WIN_SIZE];
    t_wgt         n_a_rw [WIN_SIZE];
    logic         r_a_vld;
    t_tag         r_a_tag;
    logic         r_a_in [WIN_SIZE];
    t_wgt         r_a_rw [WIN_SIZE];
    t_depth       r_a_d  [WIN_SIZE];
    // stage B: spatial weighting
    t_wgt         n_b_w [WIN_SIZE];
    logic         r_b_vld;
    t_tag         r_b_tag;
    t_wgt         r_b_w [WIN_SIZE];
    t_depth       r_b_d [WIN_SIZE];
    // stage C: weighted depth
    logic         r_c_vld;
    t_tag         r_c_tag;
    t_wgt         r_c_w    [WIN_SIZE];
    t_prod        r_c_prod [WIN_SIZE];

    always_comb begin
        t_depth                diff;
        logic [DEPTH_BITS:0]   biased;
        n_row_ok[0] = (i_tag.row != '0) && ({1'b0, i_tag.row} <= i_height);
        n_row_ok[1] = {1'b0, i_tag.row} < i_height;
        n_row_ok[2] = ({1'b0, i_tag.row} + DIM_BITS'(1)) < i_height;
        n_col_ok[0] = (i_tag.col != '0) && ({1'b0, i_tag.col} <= i_width);
        n_col_ok[1] = {1'b0, i_tag.col} < i_width;
        n_col_ok[2] = ({1'b0, i_tag.col} + DIM_BITS'(1)) < i_width;
        for (int e = 0; e < WIN_SIZE; e++) begin
            diff = (i_depth[e] >= i_tag.centre) ? i_depth[e] - i_tag.centre
                                                : i_tag.centre - i_depth[e];
            biased = {1'b0, diff} + (DEPTH_BITS + 1)'(RANGE_BIAS);
            n_a_rw[e] = range_weight(biased[DEPTH_BITS:RANGE_SHIFT]);
            n_a_in[e] = n_row_ok[WIN_ROW[e]] && n_col_ok[WIN_COL[e]];
        end
    end

    always_comb begin
        logic [2*WGT_BITS-1:0] prod;
        for (int e = 0; e < WIN_SIZE; e++) begin
            prod = (2*WGT_BITS)'(r_a_rw[e]) * (2*WGT_BITS)'(WIN_SPATIAL[e])
                 + (2*WGT_BITS)'(1 << (WGT_FRAC - 1));
            n_b_w[e] = r_a_in[e] ? WGT_BITS'(prod >> WGT_FRAC) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            for (int e = 0; e < WIN_SIZE; e++) begin
                r_a_in[e]   <= n_a_in[e];
                r_a_rw[e]   <= n_a_rw[e];
                r_a_d[e]    <= i_depth[e];
                r_b_w[e]    <= n_b_w[e];
                r_b_d[e]    <= r_a_d[e];
                r_c_w[e]    <= r_b_w[e];
                r_c_prod[e] <= PROD_BITS'(r_b_w[e]) * PROD_BITS'(r_b_d[e]);
            end
        end
    end

    assign o_vld  = r_c_vld;
    assign o_tag  = r_c_tag;
    assign o_wgt  = r_c_w;
    assign o_prod = r_c_prod;

endmodule

`default_nettype wire

>>> hdl/bf3d_accum.sv
`default_nettype none

module bf3d_accum import bf3d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_tag  i_tag,
    input  wire t_wgt  i_wgt  [WIN_SIZE],
    input  wire t_prod i_prod [WIN_SIZE],
    output logic       o_vld,
    output t_tag       o_tag,
    output t_wsum      o_wsum,
    output t_num       o_num
);

    logic [GRP_WSUM_BITS-1:0] n_g_w [GRP_COUNT];
    logic [GRP_NUM_BITS-1:0]  n_g_n [GRP_COUNT];
    logic [GRP_WSUM_BITS-1:0] r_g_w [GRP_COUNT];
    logic [GRP_NUM_BITS-1:0]  r_g_n [GRP_COUNT];
    logic                     r_g_vld;
    t_tag                     r_g_tag;
    t_wsum                    n_wsum;
    t_num                     n_num;
    logic                     r_vld;
    t_tag                     r_tag;
    t_wsum                    r_wsum;
    t_num                     r_num;

    always_comb begin
        for (int g = 0; g < GRP_COUNT; g++) begin
            n_g_w[g] = '0;
            n_g_n[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                n_g_w[g] = n_g_w[g] + GRP_WSUM_BITS'(i_wgt[g*GRP_SIZE + j]);
                n_g_n[g] = n_g_n[g] + GRP_NUM_BITS'(i_prod[g*GRP_SIZE + j]);
            end
        end
    end

    always_comb begin
        n_wsum = '0;
        n_num  = '0;
        for (int g = 0; g < GRP_COUNT; g++) begin
            n_wsum = n_wsum + WSUM_BITS'(r_g_w[g]);
            n_num  = n_num + NUM_BITS'(r_g_n[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_g_vld <= i_vld;
            r_vld   <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_w   <= n_g_w;
            r_g_n   <= n_g_n;
            r_g_tag <= i_tag;
            r_tag   <= r_g_tag;
            r_wsum  <= n_wsum;
            r_num   <= n_num;
        end
    end

    assign o_vld  = r_vld;
    assign o_tag  = r_tag;
    assign o_wsum = r_wsum;
    assign o_num  = r_num;

endmodule

`default_nettype wire

>>> hdl/bf3d_div.sv
`default_nettype none

module bf3d_div import bf3d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_tag  i_tag,
    input  wire t_wsum i_wsum,
    input  wire t_num  i_num,
    output logic       o_vld,
    output t_tag       o_tag,
    output t_depth     o_quot
);

    localparam int QB = DEPTH_BITS;

    // restoring divider, one quotient bit per stage; quotient fits QB bits
    t_num   n_dividend;
    logic   r_vld  [QB+1];
    t_tag   r_tag  [QB+1];
    logic   r_zero [QB+1];
    t_wsum  r_den  [QB+1];
    t_wsum  r_rem  [QB+1];
    t_depth r_lo   [QB+1];
    t_depth r_q    [QB+1];

    assign n_dividend = i_num + NUM_BITS'(i_wsum >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_zero[0] <= (i_wsum == '0);
            r_den[0]  <= i_wsum;
            r_rem[0]  <= n_dividend[QB +: WSUM_BITS];
            r_lo[0]   <= n_dividend[QB-1:0];
            r_q[0]    <= '0;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [WSUM_BITS:0] w_trial;
        logic [WSUM_BITS:0] w_diff;
        logic               w_ge;
        t_wsum              n_rem;

        always_comb begin
            w_trial = {r_rem[s], r_lo[s][QB-1]};
            w_diff  = w_trial - {1'b0, r_den[s]};
            w_ge    = w_trial >= {1'b0, r_den[s]};
            n_rem   = w_ge ? w_diff[WSUM_BITS-1:0] : w_trial[WSUM_BITS-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1]  <= r_tag[s];
                r_zero[s+1] <= r_zero[s];
                r_den[s+1]  <= r_den[s];
                r_rem[s+1]  <= n_rem;
                r_lo[s+1]   <= {r_lo[s][QB-2:0], 1'b0};
                r_q[s+1]    <= {r_q[s][QB-2:0], w_ge};
            end
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_tag  = r_tag[QB];
    assign o_quot = r_zero[QB] ? '0 : r_q[QB];

`ifndef SYNTH
    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !r_zero[0] |-> r_rem[0] < r_den[0])
        else $error("divider: quotient would overflow");

    a_rem_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && !r_zero[QB] |-> r_rem[QB] < r_den[QB])
        else $error("divider: final remainder not below divisor");

    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_zero[0] |-> (r_rem[0] == '0) && (r_lo[0] == '0))
        else $error("divider: zero weight sum with nonzero numerator");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && $past(i_rst_n) && !$past(i_en) |-> $stable(r_q[QB]))
        else $error("divider: quotient moved during stall");
`endif

endmodule

`default_nettype wire
